>>> rtl/core/dsoe_pkg.sv
// ----------------------------------------------------------------------------
// dsoe_pkg
// Codes, path tables and object identifier tables for the signed-data digest
// algorithm extractor.
// ----------------------------------------------------------------------------
package dsoe_pkg;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_MALFORMED   = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  localparam logic [2:0] PH_TAG  = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_LONG = 3'd2;
  localparam logic [2:0] PH_BODY = 3'd3;

  localparam logic [1:0] ACT_ENTER = 2'd0;
  localparam logic [1:0] ACT_SKIP  = 2'd1;
  localparam logic [1:0] ACT_OID   = 2'd2;

  localparam logic [3:0] LAST_STEP = 4'd13;

  localparam int OID_COUNT   = 6;
  localparam int OID_MAX_LEN = 10;

  localparam logic [7:0] TAG_SEQ     = 8'h30;
  localparam logic [7:0] TAG_CTX0    = 8'hA0;
  localparam logic [7:0] TAG_OID     = 8'h06;
  localparam logic [7:0] TAG_INT     = 8'h02;
  localparam logic [7:0] TAG_SET     = 8'h31;
  localparam logic [7:0] TAG_UNUSED  = 8'h00;

  // signedData, indirect data, sha-1, sha-256, sha-384, sha-512
  localparam logic [7:0] OID_BYTES [OID_COUNT][OID_MAX_LEN] = '{
    '{8'h2A, 8'h86, 8'h48, 8'h86, 8'hF7, 8'h0D, 8'h01, 8'h07, 8'h02, 8'h00},
    '{8'h2B, 8'h06, 8'h01, 8'h04, 8'h01, 8'h82, 8'h37, 8'h02, 8'h01, 8'h04},
    '{8'h2B, 8'h0E, 8'h03, 8'h02, 8'h1A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h60, 8'h86, 8'h48, 8'h01, 8'h65, 8'h03, 8'h04, 8'h02, 8'h01, 8'h00},
    '{8'h60, 8'h86, 8'h48, 8'h01, 8'h65, 8'h03, 8'h04, 8'h02, 8'h02, 8'h00},
    '{8'h60, 8'h86, 8'h48, 8'h01, 8'h65, 8'h03, 8'h04, 8'h02, 8'h03, 8'h00}
  };

  localparam logic [3:0] OID_LENS [OID_COUNT] = '{4'd9, 4'd10, 4'd5, 4'd9, 4'd9, 4'd9};

  typedef struct packed {
    logic [OID_COUNT-1:0] len_mask;
    logic [OID_COUNT-1:0] body_mask;
  } oid_info_t;

  function automatic logic [7:0] step_tag(input logic [3:0] step);
    logic [7:0] t;
    case (step)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd10, 4'd11, 4'd12: t = TAG_SEQ;
      4'd1, 4'd7, 4'd13:                           t = TAG_OID;
      4'd2, 4'd8:                                  t = TAG_CTX0;
      4'd4:                                        t = TAG_INT;
      4'd5:                                        t = TAG_SET;
      default:                                     t = TAG_UNUSED;
    endcase
    return t;
  endfunction

  function automatic logic [1:0] step_act(input logic [3:0] step);
    logic [1:0] a;
    case (step)
      4'd0, 4'd2, 4'd3, 4'd6, 4'd8, 4'd9, 4'd11, 4'd12: a = ACT_ENTER;
      4'd1, 4'd7, 4'd13:                                a = ACT_OID;
      default:                                          a = ACT_SKIP;
    endcase
    return a;
  endfunction

  function automatic logic [OID_COUNT-1:0] step_cands(input logic [3:0] step);
    logic [OID_COUNT-1:0] c;
    case (step)
      4'd1:    c = 6'h01;
      4'd7:    c = 6'h02;
      4'd13:   c = 6'h3C;
      default: c = 6'h00;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/dsoe_oid_match.sv
// ----------------------------------------------------------------------------
// dsoe_oid_match
// Object identifier candidate filter: length match for the current path step
// and byte-by-byte body match against the known identifiers.
// ----------------------------------------------------------------------------
module dsoe_oid_match
  import dsoe_pkg::*;
(
  input  logic [3:0]           path_step,
  input  logic [31:0]          len,
  input  logic [3:0]           oid_offset,
  input  logic [7:0]           data_byte,
  input  logic [OID_COUNT-1:0] match_mask,
  output oid_info_t            info
);

  logic [OID_COUNT-1:0] cands;
  logic                 offset_ok;

  assign cands     = step_cands(path_step);
  assign offset_ok = (oid_offset < 4'(OID_MAX_LEN));

  always_comb begin
    info = '0;
    for (int k = 0; k < OID_COUNT; k++) begin
      info.len_mask[k]  = cands[k] && (len == {28'd0, OID_LENS[k]});
      info.body_mask[k] = match_mask[k] && offset_ok &&
                          (OID_BYTES[k][offset_ok ? oid_offset : 4'd0] == data_byte);
    end
  end

endmodule

>>> rtl/core/der_signeddata_digest_oid_extractor.sv
// ----------------------------------------------------------------------------
// der_signeddata_digest_oid_extractor
// Walks the signed-data structure one byte per request and reports the
// digest algorithm, or why the blob was rejected, once per blob.
// Result: deciding byte passes the input register, then the output register.
// Throughput: one byte per cycle while the output is not stalled; the per-byte
// state update is a single register stage fed by a one-entry input register.
// Reset: synchronous, clears the parse to the state before any blob, so a
// byte without first_byte set is rejected once.
// ----------------------------------------------------------------------------
module der_signeddata_digest_oid_extractor
  import dsoe_pkg::*;
#(
  parameter longint unsigned MAX_BLOB_BYTES = 64'd16777216
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic [23:0] blob_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [1:0]  hash_alg
);

  localparam int POS_W = (MAX_BLOB_BYTES < 64'd16777216) ?
                         $clog2(MAX_BLOB_BYTES + 64'd1) : 24;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_BLOB_BYTES);

  // input register
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_first;
  logic [23:0] s1_size;
  logic        advance;

  // parse state
  logic [3:0]           path_step;
  logic [2:0]           item_phase;
  logic [POS_W-1:0]     byte_position;
  logic [POS_W-1:0]     container_end;
  logic [POS_W-1:0]     item_end;
  logic [31:0]          length_accum;
  logic [3:0]           octets_left;
  logic [3:0]           oid_offset;
  logic [OID_COUNT-1:0] match_mask;
  logic                 decided;

  // state seen by the current byte, after a restart if any
  logic [3:0]           c_step;
  logic [2:0]           c_phase;
  logic [POS_W-1:0]     c_pos;
  logic [POS_W-1:0]     c_cend;
  logic [POS_W-1:0]     c_iend;
  logic [31:0]          c_accum;
  logic [3:0]           c_octets;
  logic [3:0]           c_off;
  logic [OID_COUNT-1:0] c_mask;
  logic                 c_decided;
  logic [POS_W-1:0]     cend_init;

  logic [3:0]           path_step_next;
  logic [2:0]           item_phase_next;
  logic [POS_W-1:0]     byte_position_next;
  logic [POS_W-1:0]     container_end_next;
  logic [POS_W-1:0]     item_end_next;
  logic [31:0]          length_accum_next;
  logic [3:0]           octets_left_next;
  logic [3:0]           oid_offset_next;
  logic [OID_COUNT-1:0] match_mask_next;
  logic                 decided_next;

  logic [POS_W-1:0] pos1;
  logic [POS_W-1:0] rem1;
  logic [31:0]      accum_new;
  logic [31:0]      len_sel;
  logic [1:0]       act;
  oid_info_t        oid_info;

  logic       res_valid;
  logic [1:0] res_status;
  logic [1:0] res_alg;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  assign cend_init = ({40'd0, s1_size} < MAX_BLOB_BYTES) ? s1_size[POS_W-1:0] : MAX_POS;

  assign c_step    = s1_first ? 4'd0 : path_step;
  assign c_phase   = s1_first ? PH_TAG : item_phase;
  assign c_pos     = s1_first ? '0 : byte_position;
  assign c_cend    = s1_first ? cend_init : container_end;
  assign c_iend    = s1_first ? '0 : item_end;
  assign c_accum   = s1_first ? 32'd0 : length_accum;
  assign c_octets  = s1_first ? 4'd0 : octets_left;
  assign c_off     = s1_first ? 4'd0 : oid_offset;
  assign c_mask    = s1_first ? '1 : match_mask;
  assign c_decided = s1_first ? 1'b0 : decided;

  assign pos1      = c_pos + POS_W'(1);
  assign rem1      = c_cend - pos1;
  assign accum_new = (c_accum > 32'h00FF_FFFF) ? 32'hFFFF_FFFF : {c_accum[23:0], s1_byte};
  assign len_sel   = (c_phase == PH_LEN) ? {24'd0, s1_byte} : accum_new;
  assign act       = step_act(c_step);

  dsoe_oid_match u_oid_match (
    .path_step  (c_step),
    .len        (len_sel),
    .oid_offset (c_off),
    .data_byte  (s1_byte),
    .match_mask (c_mask),
    .info       (oid_info)
  );

  always_comb begin
    logic fin_len;
    logic fin_oid;
    fin_len = 1'b0;
    fin_oid = 1'b0;
    path_step_next     = c_step;
    item_phase_next    = c_phase;
    byte_position_next = c_pos;
    container_end_next = c_cend;
    item_end_next      = c_iend;
    length_accum_next  = c_accum;
    octets_left_next   = c_octets;
    oid_offset_next    = c_off;
    match_mask_next    = c_mask;
    res_valid  = 1'b0;
    res_status = ST_OK;
    res_alg    = 2'd0;

    if (!c_decided) begin
      if ((c_phase == PH_TAG || c_phase == PH_LEN) && c_pos >= c_cend) begin
        res_valid  = 1'b1;
        res_status = ST_MALFORMED;
      end else begin
        case (c_phase)
          PH_TAG: begin
            if (c_step > LAST_STEP || s1_byte != step_tag(c_step)) begin
              res_valid  = 1'b1;
              res_status = ST_MALFORMED;
            end else begin
              byte_position_next = pos1;
              item_phase_next    = PH_LEN;
            end
          end
          PH_LEN: begin
            byte_position_next = pos1;
            if (!s1_byte[7]) begin
              fin_len = 1'b1;
            end else if (s1_byte[6:0] == 7'd0 || s1_byte[6:0] > 7'd8 ||
                         {25'd0, s1_byte[6:0]} > 32'(rem1)) begin
              res_valid  = 1'b1;
              res_status = ST_MALFORMED;
            end else begin
              octets_left_next  = s1_byte[3:0];
              length_accum_next = 32'd0;
              item_phase_next   = PH_LONG;
            end
          end
          PH_LONG: begin
            byte_position_next = pos1;
            length_accum_next  = accum_new;
            octets_left_next   = c_octets - 4'd1;
            if (c_octets == 4'd1) begin
              fin_len = 1'b1;
            end
          end
          PH_BODY: begin
            byte_position_next = pos1;
            if (act == ACT_OID) begin
              match_mask_next = oid_info.body_mask;
              oid_offset_next = c_off + 4'd1;
              if (pos1 >= c_iend) begin
                fin_oid = 1'b1;
              end
            end else if (pos1 >= c_iend) begin
              path_step_next  = c_step + 4'd1;
              item_phase_next = PH_TAG;
            end
          end
          default: begin
            res_valid  = 1'b1;
            res_status = ST_MALFORMED;
          end
        endcase

        if (fin_len) begin
          if (len_sel > 32'(rem1)) begin
            res_valid  = 1'b1;
            res_status = ST_MALFORMED;
          end else begin
            item_end_next = pos1 + len_sel[POS_W-1:0];
            case (act)
              ACT_ENTER: begin
                container_end_next = item_end_next;
                path_step_next     = c_step + 4'd1;
                item_phase_next    = PH_TAG;
              end
              ACT_SKIP: begin
                if (len_sel == 32'd0) begin
                  path_step_next  = c_step + 4'd1;
                  item_phase_next = PH_TAG;
                end else begin
                  item_phase_next = PH_BODY;
                end
              end
              default: begin
                if (oid_info.len_mask == '0) begin
                  res_valid  = 1'b1;
                  res_status = (c_step == LAST_STEP) ? ST_UNSUPPORTED : ST_MALFORMED;
                end else begin
                  match_mask_next = oid_info.len_mask;
                  oid_offset_next = 4'd0;
                  item_phase_next = PH_BODY;
                end
              end
            endcase
          end
        end

        if (fin_oid) begin
          res_valid = 1'b1;
          if (c_step == LAST_STEP) begin
            if (oid_info.body_mask[2]) begin
              res_alg = 2'd0;
            end else if (oid_info.body_mask[3]) begin
              res_alg = 2'd1;
            end else if (oid_info.body_mask[4]) begin
              res_alg = 2'd2;
            end else if (oid_info.body_mask[5]) begin
              res_alg = 2'd3;
            end else begin
              res_status = ST_UNSUPPORTED;
            end
          end else if ((oid_info.body_mask & step_cands(c_step)) != '0) begin
            res_valid       = 1'b0;
            path_step_next  = c_step + 4'd1;
            item_phase_next = PH_TAG;
          end else begin
            res_status = ST_MALFORMED;
          end
        end

        if (!res_valid && (item_phase_next == PH_TAG || item_phase_next == PH_LEN) &&
            byte_position_next >= container_end_next) begin
          res_valid  = 1'b1;
          res_status = ST_MALFORMED;
        end
      end
    end

    decided_next = c_decided || res_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_byte  <= data_byte;
      s1_first <= first_byte;
      s1_size  <= blob_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      path_step     <= 4'd0;
      item_phase    <= PH_TAG;
      byte_position <= '0;
      container_end <= '0;
      item_end      <= '0;
      length_accum  <= 32'd0;
      octets_left   <= 4'd0;
      oid_offset    <= 4'd0;
      match_mask    <= '1;
      decided       <= 1'b0;
    end else if (advance) begin
      path_step     <= path_step_next;
      item_phase    <= item_phase_next;
      byte_position <= byte_position_next;
      container_end <= container_end_next;
      item_end      <= item_end_next;
      length_accum  <= length_accum_next;
      octets_left   <= octets_left_next;
      oid_offset    <= oid_offset_next;
      match_mask    <= match_mask_next;
      decided       <= decided_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance && res_valid) begin
      status   <= res_status;
      hash_alg <= (res_status == ST_OK) ? res_alg : 2'd0;
    end
  end

  // hash algorithm only reported on success
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || hash_alg == 2'd0))
    else $error("hash_alg set on a failed blob");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_MALFORMED || status == ST_UNSUPPORTED))
    else $error("undefined status code");

  // one result per blob
  assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid) |=> decided)
    else $error("result given without marking the blob decided");

  assert property (@(posedge clk) disable iff (rst)
    byte_position <= container_end)
    else $error("parse position past the container end");

endmodule

>>> dv/der_signeddata_digest_oid_extractor_tb.sv
// ----------------------------------------------------------------------------
// der_signeddata_digest_oid_extractor_tb
// Streams DER signed-data blobs into the extractor one request per byte:
// short rejects, well-formed blobs with random content, damaged blobs and
// loose bytes. Both sides idle and stall at random. A built-in path walker
// predicts each blob's status and digest algorithm, and every response is
// compared in order against it.
// ----------------------------------------------------------------------------
module der_signeddata_digest_oid_extractor_tb
  import dsoe_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] octets_t[$];

  typedef struct packed {
    logic [1:0] code;
    logic [1:0] alg;
  } verdict_t;

  localparam int OID_SIGNED   = 0;
  localparam int OID_INDIRECT = 1;
  localparam int OID_SHA1     = 2;

  localparam logic [3:0] SIGNED_STEP   = 4'd1;
  localparam logic [3:0] INDIRECT_STEP = 4'd7;

  localparam logic [7:0] PATH_TAG [16] = '{
    TAG_SEQ, TAG_OID, TAG_CTX0, TAG_SEQ, TAG_INT, TAG_SET, TAG_SEQ, TAG_OID,
    TAG_CTX0, TAG_SEQ, TAG_SEQ, TAG_SEQ, TAG_SEQ, TAG_OID, TAG_UNUSED, TAG_UNUSED
  };
  localparam logic [1:0] PATH_ACT [16] = '{
    ACT_ENTER, ACT_OID, ACT_ENTER, ACT_ENTER, ACT_SKIP, ACT_SKIP, ACT_ENTER, ACT_OID,
    ACT_ENTER, ACT_ENTER, ACT_SKIP, ACT_ENTER, ACT_ENTER, ACT_OID, ACT_SKIP, ACT_SKIP
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        first_byte = 1'b0;
  logic [23:0] blob_size = 24'h000000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [1:0]  hash_alg;

  der_signeddata_digest_oid_extractor dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .blob_size  (blob_size),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .hash_alg   (hash_alg)
  );

  verdict_t    pending_verdicts[$];
  int unsigned errors = 0;
  int unsigned live_bytes = 0;
  int unsigned blobs_started = 0;
  int unsigned ok_count = 0;
  int unsigned malformed_count = 0;
  int unsigned unsupported_count = 0;
  bit          calm = 1'b0;
  bit          garble_lengths = 1'b0;

  // path walker state
  logic [3:0]      pr_step = 4'd0;
  logic [2:0]      pr_phase = PH_TAG;
  longint unsigned pr_pos = 0;
  longint unsigned pr_cend = 0;
  longint unsigned pr_iend = 0;
  logic [31:0]     pr_accum = 32'd0;
  logic [3:0]      pr_octets = 4'd0;
  logic [3:0]      pr_oid_idx = 4'd0;
  logic [5:0]      pr_mask = 6'h3F;
  bit              pr_decided = 1'b0;
  bit              verdict_due = 1'b0;
  logic [1:0]      verdict_code = ST_OK;
  logic [1:0]      verdict_alg = 2'd0;

  initial forever #2 clk = ~clk;

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [5:0] oid_candidates(input logic [3:0] step);
    logic [5:0] c;
    c = 6'h00;
    if (step == SIGNED_STEP) c[OID_SIGNED] = 1'b1;
    if (step == INDIRECT_STEP) c[OID_INDIRECT] = 1'b1;
    if (step == LAST_STEP) c = 6'h3C;
    return c;
  endfunction

  function automatic void record_verdict(input logic [1:0] code, input logic [1:0] alg);
    if (!pr_decided) begin
      pr_decided = 1'b1;
      verdict_due = 1'b1;
      verdict_code = code;
      verdict_alg = (code == ST_OK) ? alg : 2'd0;
    end
  endfunction

  function automatic void close_length(input longint unsigned len);
    logic [5:0] cands;
    logic [5:0] fits;
    cands = oid_candidates(pr_step);
    fits = 6'h00;
    if (len > pr_cend - pr_pos) begin
      record_verdict(ST_MALFORMED, 2'd0);
    end else begin
      pr_iend = pr_pos + len;
      case (PATH_ACT[pr_step])
        ACT_ENTER: begin
          pr_cend = pr_iend;
          pr_step = pr_step + 4'd1;
          pr_phase = PH_TAG;
        end
        ACT_SKIP: begin
          if (len == 0) begin
            pr_step = pr_step + 4'd1;
            pr_phase = PH_TAG;
          end else begin
            pr_phase = PH_BODY;
          end
        end
        default: begin
          for (int k = 0; k < OID_COUNT; k++)
            if (cands[k] && OID_LENS[k] == len) fits[k] = 1'b1;
          if (fits == 6'h00) begin
            record_verdict(pr_step == LAST_STEP ? ST_UNSUPPORTED : ST_MALFORMED, 2'd0);
          end else begin
            pr_mask = fits;
            pr_oid_idx = 4'd0;
            pr_phase = PH_BODY;
          end
        end
      endcase
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic fb,
                                       input logic [23:0] sz);
    logic [6:0] n;
    bit found;
    verdict_due = 1'b0;
    found = 1'b0;
    n = b[6:0];
    if (fb) begin
      pr_step = 4'd0;
      pr_phase = PH_TAG;
      pr_pos = 0;
      pr_cend = sz;
      pr_iend = 0;
      pr_accum = 32'd0;
      pr_octets = 4'd0;
      pr_oid_idx = 4'd0;
      pr_mask = 6'h3F;
      pr_decided = 1'b0;
      blobs_started++;
    end
    live_bytes++;
    if (!pr_decided && (pr_phase == PH_TAG || pr_phase == PH_LEN) && pr_pos >= pr_cend)
      record_verdict(ST_MALFORMED, 2'd0);
    if (!pr_decided) begin
      case (pr_phase)
        PH_TAG: begin
          if (pr_step > LAST_STEP || b != PATH_TAG[pr_step]) begin
            record_verdict(ST_MALFORMED, 2'd0);
          end else begin
            pr_pos++;
            pr_phase = PH_LEN;
          end
        end
        PH_LEN: begin
          pr_pos++;
          if (!b[7]) begin
            close_length(longint'(b));
          end else if (n == 0 || n > 7'd8 || longint'(n) > pr_cend - pr_pos) begin
            record_verdict(ST_MALFORMED, 2'd0);
          end else begin
            pr_octets = n[3:0];
            pr_accum = 32'd0;
            pr_phase = PH_LONG;
          end
        end
        PH_LONG: begin
          pr_pos++;
          if (pr_accum > 32'h00FF_FFFF) pr_accum = 32'hFFFF_FFFF;
          else pr_accum = {pr_accum[23:0], b};
          pr_octets = pr_octets - 4'd1;
          if (pr_octets == 4'd0) close_length(longint'(pr_accum));
        end
        PH_BODY: begin
          pr_pos++;
          if (PATH_ACT[pr_step] == ACT_OID) begin
            for (int k = 0; k < OID_COUNT; k++)
              if (pr_oid_idx >= OID_MAX_LEN || OID_BYTES[k][pr_oid_idx] != b)
                pr_mask[k] = 1'b0;
            pr_oid_idx = pr_oid_idx + 4'd1;
            if (pr_pos >= pr_iend) begin
              if (pr_step == LAST_STEP) begin
                for (int k = OID_SHA1; k < OID_COUNT; k++)
                  if (!found && pr_mask[k]) begin
                    record_verdict(ST_OK, 2'(k - OID_SHA1));
                    found = 1'b1;
                  end
                if (!found) record_verdict(ST_UNSUPPORTED, 2'd0);
              end else if ((pr_mask & oid_candidates(pr_step)) != 6'h00) begin
                pr_step = pr_step + 4'd1;
                pr_phase = PH_TAG;
              end else begin
                record_verdict(ST_MALFORMED, 2'd0);
              end
            end
          end else if (pr_pos >= pr_iend) begin
            pr_step = pr_step + 4'd1;
            pr_phase = PH_TAG;
          end
        end
        default: record_verdict(ST_MALFORMED, 2'd0);
      endcase
    end
    if (!pr_decided && (pr_phase == PH_TAG || pr_phase == PH_LEN) && pr_pos >= pr_cend)
      record_verdict(ST_MALFORMED, 2'd0);
  endfunction

  function automatic octets_t rand_octets(input int unsigned count);
    octets_t q;
    repeat (count) q.push_back(8'($urandom));
    return q;
  endfunction

  function automatic octets_t oid_prefix(input int k);
    octets_t q;
    for (int i = 0; i < OID_LENS[k]; i++) q.push_back(OID_BYTES[k][i]);
    return q;
  endfunction

  function automatic octets_t tlv(input logic [7:0] tag, input octets_t body);
    octets_t q;
    int unsigned len;
    int unsigned nb;
    len = body.size();
    q.push_back(tag);
    if (garble_lengths && $urandom_range(29, 0) == 0) begin
      nb = $urandom_range(9, 0);
      q.push_back(8'h80 | 8'(nb));
      repeat (nb) q.push_back(8'($urandom));
    end else if (len < 128 && $urandom_range(3, 0) != 0) begin
      q.push_back(8'(len));
    end else begin
      nb = (len < 256) ? 1 : (len < 65536) ? 2 : 3;
      if ($urandom_range(3, 0) == 0) nb = $urandom_range(8, nb);
      q.push_back(8'h80 | 8'(nb));
      for (int i = nb - 1; i >= 0; i--) q.push_back(8'(len >> (8 * i)));
    end
    q = {q, body};
    return q;
  endfunction

  // digest_kind: 0..3 known digest, 4 random body, 5 known digest with one bit off
  function automatic octets_t make_blob(input int unsigned digest_kind);
    octets_t body;
    octets_t d;
    octets_t head;
    int unsigned pick;
    case (digest_kind)
      4: body = rand_octets($urandom_range(12, 0));
      5: begin
        body = oid_prefix(OID_SHA1 + $urandom_range(3, 0));
        pick = $urandom_range(body.size() - 1, 0);
        body[pick] = body[pick] ^ (8'h01 << $urandom_range(7, 0));
      end
      default: body = oid_prefix(OID_SHA1 + digest_kind);
    endcase
    d = tlv(TAG_OID, body);
    if ($urandom_range(3, 0) == 0) begin
      head = rand_octets($urandom_range(4, 1));
      d = {d, head};
    end
    d = tlv(TAG_SEQ, d);
    d = tlv(TAG_SEQ, d);
    head = tlv(TAG_SEQ, rand_octets($urandom_range(15, 0) == 0 ?
                                    $urandom_range(300, 128) : $urandom_range(6, 0)));
    d = {head, d};
    d = tlv(TAG_SEQ, d);
    d = tlv(TAG_CTX0, d);
    head = tlv(TAG_OID, oid_prefix(OID_INDIRECT));
    d = {head, d};
    d = tlv(TAG_SEQ, d);
    head = tlv(TAG_SET, rand_octets($urandom_range(8, 0)));
    d = {head, d};
    head = tlv(TAG_INT, rand_octets($urandom_range(3, 0)));
    d = {head, d};
    d = tlv(TAG_SEQ, d);
    d = tlv(TAG_CTX0, d);
    head = tlv(TAG_OID, oid_prefix(OID_SIGNED));
    d = {head, d};
    d = tlv(TAG_SEQ, d);
    if ($urandom_range(4, 0) == 0) begin
      head = rand_octets($urandom_range(3, 1));
      d = {d, head};
    end
    return d;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fb, input logic [23:0] sz);
    if (!calm && $urandom_range(99, 0) < 25) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < 25);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    first_byte <= fb;
    blob_size  <= sz;
    do @(posedge clk); while (in_stall);
    predict_byte(b, fb, sz);
    if (verdict_due) pending_verdicts.push_back({verdict_code, verdict_alg});
  endtask

  task automatic send_blob(input octets_t blob, input logic [23:0] sz);
    foreach (blob[i]) send_byte(blob[i], i == 0, i == 0 ? sz : 24'($urandom));
  endtask

  task automatic test_early_rejects();
    octets_t seq;
    send_byte(8'h30, 1'b0, 24'd0);
    send_byte(8'h30, 1'b1, 24'd0);
    send_byte(8'hFF, 1'b1, 24'hFFFFFF);
    seq = '{8'h30};
    send_blob(seq, 24'd1);
    seq = '{8'h30, 8'h00};
    send_blob(seq, 24'd2);
    seq = '{8'h30, 8'h80};
    send_blob(seq, 24'd10);
    seq = '{8'h30, 8'h89};
    send_blob(seq, 24'd20);
    seq = '{8'h30, 8'h84};
    send_blob(seq, 24'd4);
    seq = '{8'h30, 8'h81, 8'h50};
    send_blob(seq, 24'd40);
    seq = '{8'h30, 8'h85, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
    send_blob(seq, 24'd40);
    seq = '{8'h30, 8'h06, 8'h06, 8'h03};
    send_blob(seq, 24'd8);
    send_byte(8'h00, 1'b0, 24'hFFFFFF);
    send_byte(8'h06, 1'b0, 24'h000000);
  endtask

  task automatic test_wellformed_blobs();
    octets_t blob;
    int unsigned kind;
    calm = 1'b1;
    while (live_bytes < 1200) begin
      if (live_bytes > 500) calm = 1'b0;
      kind = $urandom_range(9, 0);
      blob = make_blob(kind < 8 ? kind % 4 : kind - 4);
      send_blob(blob, 24'(blob.size()));
      if ($urandom_range(3, 0) == 0) send_byte(8'($urandom), 1'b0, 24'($urandom));
    end
    calm = 1'b0;
  endtask

  task automatic test_drain_pause();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  task automatic test_damaged_blobs();
    octets_t blob;
    logic [23:0] sz;
    int unsigned cut;
    garble_lengths = 1'b1;
    while (live_bytes < 1750) begin
      blob = make_blob($urandom_range(5, 0));
      sz = 24'(blob.size());
      case ($urandom_range(4, 0))
        0: blob[$urandom_range(blob.size() - 1, 0)] = 8'($urandom);
        1: sz = 24'($urandom_range(blob.size() - 1, 0));
        2: sz = 24'($urandom);
        3: begin
          cut = $urandom_range(blob.size() - 1, 1);
          blob = blob[0:cut - 1];
        end
        default: ;
      endcase
      send_blob(blob, sz);
    end
    garble_lengths = 1'b0;
  endtask

  task automatic test_loose_bytes();
    logic [7:0] b;
    logic fb;
    while (live_bytes < 1950) begin
      fb = ($urandom_range(3, 0) == 0);
      b = $urandom_range(1, 0) ? PATH_TAG[$urandom_range(13, 0)] : 8'($urandom);
      send_byte(b, fb, $urandom_range(3, 0) == 0 ? 24'($urandom) : 24'($urandom_range(8, 0)));
    end
  endtask

  always @(posedge clk) out_stall <= !rst && !calm && ($urandom_range(99, 0) < 25);

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      case (status)
        ST_OK:          ok_count++;
        ST_MALFORMED:   malformed_count++;
        ST_UNSUPPORTED: unsupported_count++;
        default: ;
      endcase
      if (pending_verdicts.size() == 0) begin
        $error("response with nothing pending: status %0d hash_alg %0d", status, hash_alg);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (status !== want.code) begin
          $error("status: expected %0d, got %0d", want.code, status);
          errors++;
        end
        if (hash_alg !== want.alg) begin
          $error("hash_alg: expected %0d, got %0d", want.alg, hash_alg);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_early_rejects();
    test_wellformed_blobs();
    test_drain_pause();
    test_damaged_blobs();
    test_loose_bytes();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("parsed %0d bytes over %0d blobs, early rejects to loose bytes",
             live_bytes, blobs_started);
    $display("responses: %0d digest found, %0d malformed, %0d unsupported digest",
             ok_count, malformed_count, unsupported_count);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
